/* hdl/isq_pkg.sv */
package isq_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned ITEM_W     = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY_RM   = 2'd2,
    ST_EMPTY_DUMP = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_FROM_LEFT,
    ACT_FROM_RIGHT,
    ACT_FROM_HEAD
  } cell_act_e;

  typedef struct packed {
    cell_act_e act;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [ITEM_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [ITEM_W-1:0] item_value;
    logic [1:0]               status;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } out_item_t;

endpackage

/* hdl/isq_cell.sv */
module isq_cell (
  input  logic                            clk_i,
  input  isq_pkg::cell_ctrl_t             ctrl_i,
  input  logic [isq_pkg::DATA_WIDTH-1:0]  new_i,
  input  logic [isq_pkg::DATA_WIDTH-1:0]  left_i,
  input  logic [isq_pkg::DATA_WIDTH-1:0]  right_i,
  input  logic [isq_pkg::DATA_WIDTH-1:0]  head_i,
  output logic [isq_pkg::DATA_WIDTH-1:0]  data_o
);

  logic [isq_pkg::DATA_WIDTH-1:0] data_q;
  logic [isq_pkg::DATA_WIDTH-1:0] data_d;

  always_comb begin
    case (ctrl_i.act)
      isq_pkg::ACT_LOAD:       data_d = new_i;
      isq_pkg::ACT_FROM_LEFT:  data_d = left_i;
      isq_pkg::ACT_FROM_RIGHT: data_d = right_i;
      isq_pkg::ACT_FROM_HEAD:  data_d = head_i;
      default:                 data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* hdl/indexed_sequence_store_core.sv */
// Ordered store of up to CAPACITY entries held in a row of shifting cells.
// An insert or remove at any position completes in the cycle it is accepted
// and yields one result; every cell from the target slot to the end of the
// stored entries moves at once toward or away from it. A dump of n stored
// entries is accepted, then emits one entry at a time, each held back by
// any stall on the result side. The row rotates by one cell as each head
// entry is emitted, so the order is restored once the dump is done. No new
// item is accepted while a dump is running. Results sit in one output
// register, and a new item is taken while that register is drained in the
// same cycle.
module indexed_sequence_store_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isq_pkg::in_item_t   in_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output isq_pkg::out_item_t  out_data_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);

  localparam int unsigned CAP = isq_pkg::CAPACITY;
  localparam int unsigned DW  = isq_pkg::DATA_WIDTH;
  localparam int unsigned LW  = isq_pkg::LEN_W;

  isq_pkg::state_e    state_q, state_d;
  logic [isq_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [isq_pkg::CNT_W-1:0] dump_idx_q, dump_idx_d;
  isq_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  isq_pkg::cell_ctrl_t ctrl [CAP];
  logic [DW-1:0]       cell_data [CAP];
  logic [DW-1:0]       rd_or;

  logic          in_accept;
  logic          out_free;
  logic [LW-1:0] n7;
  logic [LW-1:0] pos_ins;
  logic [LW-1:0] pos_rm;
  logic          dump_last;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != isq_pkg::S_IDLE) || !out_free;
  assign in_accept = in_valid_i && !in_stall_o;
  assign n7        = LW'(cnt_q);
  assign pos_ins   = (in_data_i.position > n7) ? n7 : in_data_i.position;
  assign pos_rm    = (in_data_i.position > n7 - LW'(1)) ? n7 - LW'(1) : in_data_i.position;
  assign dump_last = (dump_idx_q == cnt_q - isq_pkg::CNT_W'(1));

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAP; i++) begin
      if (LW'(i) == pos_rm) begin
        rd_or = rd_or | cell_data[i];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      isq_pkg::S_IDLE: begin
        if (in_accept && in_data_i.op == isq_pkg::OP_DUMP && cnt_q != '0) begin
          state_d = isq_pkg::S_DUMP;
        end
      end
      isq_pkg::S_DUMP: begin
        if (out_free && dump_last) begin
          state_d = isq_pkg::S_IDLE;
        end
      end
      default: state_d = isq_pkg::S_IDLE;
    endcase
  end

  // outputs and cell control
  always_comb begin
    logic [LW-1:0] iv;
    iv          = '0;
    cnt_d       = cnt_q;
    dump_idx_d  = dump_idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    for (int i = 0; i < CAP; i++) begin
      ctrl[i].act = isq_pkg::ACT_HOLD;
    end

    case (state_q)
      isq_pkg::S_IDLE: begin
        if (in_accept) begin
          out_d.item_value = '0;
          out_d.status     = isq_pkg::ST_OK;
          out_d.last       = 1'b1;
          out_d.length     = n7;
          case (in_data_i.op)
            isq_pkg::OP_INSERT: begin
              out_valid_d = 1'b1;
              if (cnt_q >= isq_pkg::CNT_W'(CAP)) begin
                out_d.status = isq_pkg::ST_FULL;
              end else begin
                for (int i = 0; i < CAP; i++) begin
                  iv = LW'(i);
                  if (iv == pos_ins) begin
                    ctrl[i].act = isq_pkg::ACT_LOAD;
                  end else if (iv > pos_ins && iv <= n7) begin
                    ctrl[i].act = isq_pkg::ACT_FROM_LEFT;
                  end
                end
                cnt_d        = cnt_q + isq_pkg::CNT_W'(1);
                out_d.length = n7 + LW'(1);
              end
            end
            isq_pkg::OP_REMOVE: begin
              out_valid_d = 1'b1;
              if (cnt_q == '0) begin
                out_d.status = isq_pkg::ST_EMPTY_RM;
              end else begin
                for (int i = 0; i < CAP; i++) begin
                  iv = LW'(i);
                  if (iv >= pos_rm && iv < n7 - LW'(1)) begin
                    ctrl[i].act = isq_pkg::ACT_FROM_RIGHT;
                  end
                end
                cnt_d            = cnt_q - isq_pkg::CNT_W'(1);
                out_d.length     = n7 - LW'(1);
                out_d.item_value = 32'(rd_or);
              end
            end
            isq_pkg::OP_DUMP: begin
              dump_idx_d = '0;
              if (cnt_q == '0) begin
                out_valid_d  = 1'b1;
                out_d.status = isq_pkg::ST_EMPTY_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      isq_pkg::S_DUMP: begin
        if (out_free) begin
          for (int i = 0; i < CAP; i++) begin
            iv = LW'(i);
            if (iv < n7 - LW'(1)) begin
              ctrl[i].act = isq_pkg::ACT_FROM_RIGHT;
            end else if (iv == n7 - LW'(1)) begin
              ctrl[i].act = isq_pkg::ACT_FROM_HEAD;
            end
          end
          out_valid_d      = 1'b1;
          out_d.item_value = 32'(cell_data[0]);
          out_d.status     = isq_pkg::ST_OK;
          out_d.length     = n7;
          out_d.last       = dump_last;
          dump_idx_d       = dump_idx_q + isq_pkg::CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [DW-1:0] left_w;
    logic [DW-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAP - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    isq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .new_i   (DW'(unsigned'(in_data_i.value))),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isq_pkg::S_IDLE;
      cnt_q       <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

/* sim/indexed_sequence_store_core_tb.sv */
module indexed_sequence_store_core_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_REPORTS = 10;

  logic               clk_i;
  logic               rst_ni;
  isq_pkg::in_item_t  in_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  isq_pkg::out_item_t out_data_o;
  logic               out_valid_o;
  logic               out_stall_i;

  logic [isq_pkg::DATA_WIDTH-1:0] shadow_seq_q[$];
  isq_pkg::out_item_t             pending_results_q[$];

  int  errors;
  int  reports;
  int  cycle_cnt;
  int  items_accepted;
  int  results_checked;
  int  dump_cnt;
  int  full_reject_cnt;
  int  empty_reject_cnt;
  int  hold_cnt;
  bit  tx_idle_en;
  bit  rx_idle_en;
  bit  hold_req;

  indexed_sequence_store_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results_q.size());
      $display("indexed_sequence_store_core test failed");
      $finish;
    end
  end

  function automatic isq_pkg::out_item_t make_result(logic [31:0] val,
                                                     isq_pkg::status_e st, int len,
                                                     bit fin);
    isq_pkg::out_item_t r;
    r.item_value = val;
    r.status     = st;
    r.length     = isq_pkg::LEN_W'(len);
    r.last       = fin;
    return r;
  endfunction

  task automatic predict_sequence_op(isq_pkg::in_item_t it);
    int n;
    int pos;
    logic [isq_pkg::DATA_WIDTH-1:0] removed;
    n   = shadow_seq_q.size();
    pos = it.position;
    case (it.op)
      isq_pkg::OP_INSERT: begin
        if (n >= isq_pkg::CAPACITY) begin
          full_reject_cnt++;
          pending_results_q.push_back(make_result('0, isq_pkg::ST_FULL, n, 1'b1));
        end else begin
          if (pos > n) pos = n;
          shadow_seq_q.insert(pos, it.value[isq_pkg::DATA_WIDTH-1:0]);
          pending_results_q.push_back(make_result('0, isq_pkg::ST_OK, n + 1, 1'b1));
        end
      end
      isq_pkg::OP_REMOVE: begin
        if (n == 0) begin
          empty_reject_cnt++;
          pending_results_q.push_back(make_result('0, isq_pkg::ST_EMPTY_RM, 0, 1'b1));
        end else begin
          if (pos > n - 1) pos = n - 1;
          removed = shadow_seq_q[pos];
          shadow_seq_q.delete(pos);
          pending_results_q.push_back(make_result(32'(removed), isq_pkg::ST_OK, n - 1,
                                                  1'b1));
        end
      end
      isq_pkg::OP_DUMP: begin
        dump_cnt++;
        if (n == 0) begin
          pending_results_q.push_back(make_result('0, isq_pkg::ST_EMPTY_DUMP, 0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++) begin
            pending_results_q.push_back(make_result(32'(shadow_seq_q[i]), isq_pkg::ST_OK,
                                                    n, i == n - 1));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(isq_pkg::out_item_t got);
    isq_pkg::out_item_t want;
    if (pending_results_q.size() == 0) begin
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("unexpected result: value=%0d status=%0d length=%0d last=%0d",
                 got.item_value, got.status, got.length, got.last);
      end
    end else begin
      want = pending_results_q.pop_front();
      results_checked++;
      if (got.item_value !== want.item_value || got.status !== want.status ||
          got.length !== want.length || got.last !== want.last) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("mismatch: exp value=%0d status=%0d length=%0d last=%0d",
                   want.item_value, want.status, want.length, want.last);
          $display("          got value=%0d status=%0d length=%0d last=%0d",
                   got.item_value, got.status, got.length, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
      if (in_valid_i && !in_stall_o) begin
        items_accepted++;
        predict_sequence_op(in_data_i);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int g;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        g = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_stall_i <= 1'b1;
        repeat (g) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic int tx_gap();
    int r;
    if (!tx_idle_en) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [isq_pkg::POS_W-1:0] rand_position();
    if ($urandom_range(0, 1) == 0) return isq_pkg::POS_W'($urandom_range(0, 127));
    return isq_pkg::POS_W'($urandom_range(0, shadow_seq_q.size()));
  endfunction

  // called and returns at a falling edge; valid stays high after the transfer
  task automatic push_op(logic [1:0] op, logic [31:0] val,
                         logic [isq_pkg::POS_W-1:0] pos);
    int gap;
    isq_pkg::in_item_t it;
    gap = tx_gap();
    it.op       = op;
    it.value    = val;
    it.position = pos;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results_q.size() != 0 || hold_req) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic push_random(int p_ins, int p_rm, int p_dump);
    int r;
    r = $urandom_range(0, 99);
    if (r < p_ins) push_op(isq_pkg::OP_INSERT, rand_value(), rand_position());
    else if (r < p_ins + p_rm) push_op(isq_pkg::OP_REMOVE, $urandom, rand_position());
    else if (r < p_ins + p_rm + p_dump) push_op(isq_pkg::OP_DUMP, $urandom, rand_position());
    else push_op(OP_UNUSED, $urandom, rand_position());
  endtask

  task automatic test_directed();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    push_op(isq_pkg::OP_REMOVE, 32'h1234_5678, 7'd0);
    push_op(isq_pkg::OP_REMOVE, 32'h0, 7'd127);
    push_op(isq_pkg::OP_DUMP, 32'h0, 7'd0);
    push_op(OP_UNUSED, 32'hdead_beef, 7'd5);
    push_op(isq_pkg::OP_INSERT, 32'h8000_0000, 7'd0);
    push_op(isq_pkg::OP_INSERT, 32'h7fff_ffff, 7'd127);
    push_op(isq_pkg::OP_INSERT, 32'h0000_0000, 7'd1);
    push_op(isq_pkg::OP_INSERT, 32'hffff_ffff, 7'd0);
    push_op(isq_pkg::OP_INSERT, 32'h5555_5555, 7'd2);
    push_op(isq_pkg::OP_INSERT, 32'haaaa_aaaa, 7'd5);
    push_op(isq_pkg::OP_DUMP, 32'hffff_ffff, 7'd127);
    push_op(isq_pkg::OP_REMOVE, 32'h0, 7'd127);
    push_op(isq_pkg::OP_REMOVE, 32'h0, 7'd0);
    push_op(isq_pkg::OP_REMOVE, 32'h0, 7'd1);
    push_op(OP_UNUSED, 32'h0, 7'd0);
    push_op(isq_pkg::OP_DUMP, 32'h0, 7'd0);
    push_op(isq_pkg::OP_REMOVE, 32'h0, 7'd64);
    push_op(isq_pkg::OP_REMOVE, 32'h0, 7'd0);
    push_op(isq_pkg::OP_REMOVE, 32'h0, 7'd0);
    push_op(isq_pkg::OP_DUMP, 32'h0, 7'd0);
    drain();
  endtask

  task automatic test_grow_to_full();
    int extra;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    extra = 0;
    while (extra < 4) begin
      push_random(80, 10, 7);
      if (shadow_seq_q.size() == isq_pkg::CAPACITY) extra++;
    end
    push_op(isq_pkg::OP_DUMP, 32'h0, 7'd127);
    drain();
  endtask

  task automatic test_shrink_to_empty();
    int extra;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    extra = 0;
    while (extra < 4) begin
      push_random(10, 80, 7);
      if (shadow_seq_q.size() == 0) extra++;
    end
    drain();
  endtask

  task automatic test_mixed();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int i = 0; i < 40; i++) push_random(50, 35, 12);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < 20; i++) push_random(50, 35, 12);
    drain();
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) push_op(isq_pkg::OP_INSERT, rand_value(), rand_position());
    push_op(isq_pkg::OP_DUMP, 32'h0, 7'd0);
    for (int i = 0; i < 6; i++) push_op(isq_pkg::OP_REMOVE, 32'h0, rand_position());
    drain();
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_data_i        = '0;
    errors           = 0;
    reports          = 0;
    cycle_cnt        = 0;
    items_accepted   = 0;
    results_checked  = 0;
    dump_cnt         = 0;
    full_reject_cnt  = 0;
    empty_reject_cnt = 0;
    hold_cnt         = 0;
    tx_idle_en       = 1'b0;
    rx_idle_en       = 1'b0;
    hold_req         = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_grow_to_full();
    test_shrink_to_empty();
    test_mixed();
    test_backpressure();

    $display("%0d transfers in, %0d results checked, %0d dumps", items_accepted,
             results_checked, dump_cnt);
    $display("%0d inserts into a full store, %0d removes from an empty store, %0d errors",
             full_reject_cnt, empty_reject_cnt, errors);
    if (errors == 0) begin
      $display("indexed_sequence_store_core test passed");
    end else begin
      $display("indexed_sequence_store_core test failed");
    end
    $finish;
  end

endmodule
